FILE: hdl/mrt_pkg.sv
package mrt_pkg;
    localparam int ENTRIES_DEF   = 16;
    localparam int ADDR_BITS_DEF = 39;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } t_status;
endpackage

FILE: hdl/mapped_region_table_core.sv
// Mapped region table. Each command is one transaction on s_axis and yields
// one result transaction on m_axis. A command walks every slot of the region
// memory once (one read a cycle through the registered read port, then a step
// to close the walk), then may write a slot in the update state; the second
// slot of a split is written in the following cycle, which overlaps the output
// cycle. The pace of commands is set by the single read port of the slot
// memory. Commands are taken one at a time; a new command is accepted while
// the previous result is still waiting, and a result that is not taken holds
// the next one in the output stage. Slot valid bits live in flip-flops and are
// cleared by reset.
module mapped_region_table_core #(
    parameter int ENTRIES   = mrt_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = mrt_pkg::ADDR_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: cmd[1:0], start_addr[40:2], region_len[71:41], file_offset[102:72],
    //        file_id[110:103], map_flags[118:111], map_prot[121:119]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[1:0], hit_start[40:2], hit_len[71:41], hit_offset[103:72],
    //        hit_file[111:104], hit_flags[119:112], hit_prot[122:120]
    output logic [127:0] m_axis_tdata
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = ADDR_BITS;
    // slot word: start, len, offset, file, flags, prot, stamp
    localparam int SW = AW + 31 + 32 + 8 + 8 + 3 + 32;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // latched command
    logic [1:0]    r_cmd;
    logic [AW-1:0] r_s;
    logic [30:0]   r_l;
    logic [30:0]   r_foff;
    logic [7:0]    r_fid, r_fl;
    logic [2:0]    r_pr;

    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_ctr;
    logic [CW-1:0]      r_ridx;
    logic [IW-1:0]      r_cidx;
    logic               r_cval;
    logic               r_any, r_hit;
    logic [IW-1:0]      r_hidx;
    logic [31:0]        r_age;
    logic [SW-1:0]      r_hword;
    logic [127:0]       r_odata;
    logic               r_ovalid;

    logic [SW-1:0] rdata, wdata0, wdata1;
    logic          we;
    logic [IW-1:0] waddr, raddr;

    // the second write in the split case is held in r_pend, r_paddr and r_pdata
    logic          r_pend;
    logic [IW-1:0] r_paddr;
    logic [SW-1:0] r_pdata;

    mrt_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata0),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign raddr = r_ridx[IW-1:0];

    // unpack the slot read
    logic [AW-1:0] a;
    logic [30:0]   la;
    logic [31:0]   aoff, astamp;
    logic [7:0]    af, afl;
    logic [2:0]    apr;
    assign {a, la, aoff, af, afl, apr, astamp} = rdata;

    // compare current slot with command
    logic [AW:0] dsa, das;
    logic        ge, meet, contain, ok;
    logic [31:0] age;
    always_comb begin
        ge  = r_s >= a;
        dsa = {1'b0, r_s} - {1'b0, a};
        das = {1'b0, a} - {1'b0, r_s};
        meet = ge ? (dsa < {{(AW-30){1'b0}}, la}) : (das < {{(AW-30){1'b0}}, r_l});
        if (la == '0) meet = 1'b0;
        contain = ge && (dsa <= {{(AW-30){1'b0}}, la}) &&
                  ({{(AW-30){1'b0}}, r_l} + dsa <= {{(AW-30){1'b0}}, la});
        ok  = (r_cmd == mrt_pkg::CMD_REMOVE) ? contain : meet;
        age = r_ctr - astamp;
    end

    // highest free slot, and the free slot for split (excluding none)
    logic          free_any;
    logic [IW-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // hit fields
    logic [AW-1:0] ha;
    logic [30:0]   hla;
    logic [31:0]   hoff, hstamp;
    logic [7:0]    hf, hfl;
    logic [2:0]    hpr;
    assign {ha, hla, hoff, hf, hfl, hpr, hstamp} = r_hword;

    logic [AW-1:0] d;
    logic [30:0]   d31;
    logic          front, back, whole;
    logic [31:0]   piece_off;
    always_comb begin
        d     = r_s - ha;
        d31   = d[30:0];
        front = (d == '0) && (r_l < hla);
        back  = (d != '0) && ({1'b0, d31} + {1'b0, r_l} == {1'b0, hla});
        whole = (d == '0) && (r_l == hla);
        piece_off = hoff + {1'b0, d31};
    end

    logic [1:0] fstat;
    logic [AW-1:0] o_st;
    logic [30:0]   o_ln;
    logic [31:0]   o_of;
    logic [7:0]    o_fi, o_fl;
    logic [2:0]    o_pr;

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = r_hidx;
        wdata0  = r_hword;
        wdata1  = r_hword;
        fstat   = mrt_pkg::ST_OK;
        o_st = '0; o_ln = '0; o_of = '0; o_fi = '0; o_fl = '0; o_pr = '0;
        if (r_pend) begin
            we = 1'b1; waddr = r_paddr; wdata0 = r_pdata;
        end
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_SCAN;
            S_SCAN: if (r_ridx == CW'(ENTRIES) && !r_cval) n_state = S_UPD;
            S_UPD: begin
                n_state = S_OUT;
                if (r_l == '0 || r_cmd == mrt_pkg::CMD_NONE) begin
                    fstat = mrt_pkg::ST_MISS;
                end else if (r_cmd == mrt_pkg::CMD_ADD) begin
                    if (r_any) fstat = mrt_pkg::ST_OVERLAP;
                    else if (!free_any) fstat = mrt_pkg::ST_FULL;
                    else begin
                        we = 1'b1; waddr = free_idx;
                        wdata0 = {r_s, r_l, {1'b0, r_foff}, r_fid, r_fl, r_pr, r_ctr};
                    end
                end else if (!r_hit) begin
                    fstat = mrt_pkg::ST_MISS;
                end else if (r_cmd == mrt_pkg::CMD_LOOKUP) begin
                    o_st = ha; o_ln = hla; o_of = hoff; o_fi = hf; o_fl = hfl; o_pr = hpr;
                end else begin
                    o_st = r_s; o_ln = r_l; o_of = piece_off;
                    o_fi = hf; o_fl = hfl; o_pr = hpr;
                    if (front) begin
                        we = 1'b1;
                        wdata0 = {ha + AW'(r_l), hla - r_l, hoff + {1'b0, r_l},
                                  hf, hfl, hpr, hstamp};
                    end else if (back) begin
                        we = 1'b1;
                        wdata0 = {ha, d31, hoff, hf, hfl, hpr, hstamp};
                    end else if (!whole) begin
                        if (!free_any) begin
                            fstat = mrt_pkg::ST_FULL;
                            o_st = '0; o_ln = '0; o_of = '0;
                            o_fi = '0; o_fl = '0; o_pr = '0;
                        end else begin
                            we = 1'b1;
                            wdata0 = {r_s + AW'(r_l), hla - d31 - r_l,
                                      hoff + {1'b0, d31} + {1'b0, r_l},
                                      hf, hfl, hpr, hstamp};
                            wdata1 = {ha, d31, hoff, hf, hfl, hpr, r_ctr};
                        end
                    end
                end
            end
            S_OUT: if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic split_go;
    assign split_go = (r_state == S_UPD) && r_l != '0 && r_cmd == mrt_pkg::CMD_REMOVE
                      && r_hit && !front && !back && !whole && free_any;

    assign s_axis_tready = (r_state == S_IDLE) && !r_pend;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic [127:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_cval   <= 1'b0;
            r_ridx   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= split_go;
            if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready) begin
                r_cmd  <= s_axis_tdata[1:0];
                r_s    <= AW'(s_axis_tdata[40:2]);
                r_l    <= s_axis_tdata[71:41];
                r_foff <= s_axis_tdata[102:72];
                r_fid  <= s_axis_tdata[110:103];
                r_fl   <= s_axis_tdata[118:111];
                r_pr   <= s_axis_tdata[121:119];
                r_ridx <= '0;
                r_cval <= 1'b0;
                r_any  <= 1'b0;
                r_hit  <= 1'b0;
            end
            // scan: issue read, evaluate previous read
            if (r_state == S_SCAN) begin
                r_cval <= r_ridx != CW'(ENTRIES);
                if (r_ridx != CW'(ENTRIES)) r_ridx <= r_ridx + 1'b1;
                r_cidx <= r_ridx[IW-1:0];
                if (r_cval && r_valid[r_cidx]) begin
                    if (r_cmd == mrt_pkg::CMD_ADD) begin
                        if (meet) r_any <= 1'b1;
                    end else if (ok && (!r_hit || age < r_age)) begin
                        r_hit   <= 1'b1;
                        r_hidx  <= r_cidx;
                        r_age   <= age;
                        r_hword <= rdata;
                    end
                end
            end
            if (r_state == S_UPD) begin
                if (fstat == mrt_pkg::ST_OK && r_cmd == mrt_pkg::CMD_ADD) begin
                    r_valid[free_idx] <= 1'b1;
                    r_ctr <= r_ctr + 1'b1;
                end
                if (fstat == mrt_pkg::ST_OK && r_cmd == mrt_pkg::CMD_REMOVE && whole)
                    r_valid[r_hidx] <= 1'b0;
                if (split_go) begin
                    r_valid[free_idx] <= 1'b1;
                    r_ctr   <= r_ctr + 1'b1;
                    r_paddr <= free_idx;
                    r_pdata <= wdata1;
                end
                r_res <= {5'd0, o_pr, o_fl, o_fi, o_of, o_ln, 39'(o_st), fstat};
            end
            // output register: load a new result, or drop the one taken
            if (r_state == S_OUT && n_state == S_IDLE) begin
                r_ovalid <= 1'b1;
                r_odata  <= r_res;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

FILE: hdl/mrt_ram.sv
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/mrt_checker.sv
module mrt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a command is never taken right after another
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted back to back");

    // non-ok results carry zero payload
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[127:2] == '0)
        else $error("error result has payload");

    // no output right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind mapped_region_table_core mrt_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
